FILE: hdl/qrs_pkg.sv
// Package for the quadratic root solver: data width, default fraction width,
// root kind codes and the packed beat types of both channels.
// No dependencies.
package qrs_pkg;

  localparam int DataWidth     = 32;
  localparam int FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_NONE     = 2'd0,
    KIND_SINGLE   = 2'd1,
    KIND_TWO_REAL = 2'd2,
    KIND_COMPLEX  = 2'd3
  } root_kind_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] coeff_a;
    logic signed [DataWidth-1:0] coeff_b;
    logic signed [DataWidth-1:0] coeff_c;
  } coeff_t;

  typedef struct packed {
    root_kind_t                  root_kind;
    logic signed [DataWidth-1:0] first_root_real;
    logic signed [DataWidth-1:0] second_root_real;
    logic        [DataWidth-2:0] imag_magnitude;
    logic                        overflow_flag;
  } root_t;

endpackage

FILE: hdl/quadratic_root_solver.sv
// Quadratic root solver top level: decode, multiply, discriminant, pipelined
// square root, two pipelined rounding dividers, sort and saturation.
// Depends on qrs_pkg.
// With the default FRAC_BITS the real roots are Q16.16; the square root resolves
// one root bit per stage and the dividers one numerator bit per stage.
// Throughput is one beat per cycle; a stall at the output holds every stage.
// Synchronous reset clears all valid bits; data registers are not reset.
module quadratic_root_solver #(
  parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           coeff_valid,
  output logic           coeff_ready,
  input  qrs_pkg::coeff_t coeff,
  output logic           root_valid,
  input  logic           root_ready,
  output qrs_pkg::root_t root
);
  import qrs_pkg::*;

  localparam int W    = DataWidth;
  localparam int F    = FRAC_BITS;
  localparam int SQW  = 2 * W + 2;
  localparam int RW   = W + 1;
  localparam int RMW  = RW + 2;
  localparam int DENW = W + 2;
  localparam int NW   = W + F + 3;
  localparam logic [NW-1:0] SAT_POS = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [NW-1:0] SAT_NEG = SAT_POS + NW'(1);

  typedef enum logic [2:0] {
    MODE_NONE, MODE_LINEAR, MODE_DOUBLE, MODE_COMPLEX, MODE_TWO
  } mode_t;

  typedef struct packed {
    logic         an;
    logic         bn;
    logic         cn;
    logic [W-1:0] am;
    logic [W-1:0] bm;
    logic [W-1:0] cm;
    logic         dneg;
    logic         dzero;
    mode_t        mode;
  } ctx_t;

  logic adv;
  assign adv         = !root_valid || root_ready;
  assign coeff_ready = adv;

  // Decode to sign and magnitude.
  ctx_t dec_next;
  always_comb begin
    dec_next    = '0;
    dec_next.an = coeff.coeff_a[W-1];
    dec_next.bn = coeff.coeff_b[W-1];
    dec_next.cn = coeff.coeff_c[W-1];
    dec_next.am = coeff.coeff_a[W-1] ? W'(-coeff.coeff_a) : coeff.coeff_a;
    dec_next.bm = coeff.coeff_b[W-1] ? W'(-coeff.coeff_b) : coeff.coeff_b;
    dec_next.cm = coeff.coeff_c[W-1] ? W'(-coeff.coeff_c) : coeff.coeff_c;
  end

  logic v_dec;
  ctx_t d_ctx;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_dec <= 1'b0;
    end else if (adv) begin
      v_dec <= coeff_valid;
    end
    if (adv) begin
      d_ctx <= dec_next;
    end
  end

  // Products.
  logic           v_mul;
  ctx_t           m_ctx;
  logic [2*W-1:0] m_bb;
  logic [2*W-1:0] m_ac;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_mul <= 1'b0;
    end else if (adv) begin
      v_mul <= v_dec;
    end
    if (adv) begin
      m_ctx <= d_ctx;
      m_bb  <= (2*W)'(d_ctx.bm) * (2*W)'(d_ctx.bm);
      m_ac  <= (2*W)'(d_ctx.am) * (2*W)'(d_ctx.cm);
    end
  end

  // Discriminant magnitude and sign.
  logic [SQW-1:0] ac4;
  logic [SQW-1:0] bbx;
  logic [SQW-1:0] dmag;
  logic           dneg;
  ctx_t           sq_ctx_next;
  always_comb begin
    ac4  = {m_ac, 2'b00};
    bbx  = SQW'(m_bb);
    dneg = 1'b0;
    if (m_ctx.an != m_ctx.cn || ac4 == '0) begin
      dmag = bbx + ac4;
    end else if (bbx >= ac4) begin
      dmag = bbx - ac4;
    end else begin
      dmag = ac4 - bbx;
      dneg = 1'b1;
    end
    sq_ctx_next       = m_ctx;
    sq_ctx_next.dneg  = dneg;
    sq_ctx_next.dzero = (dmag == '0);
  end

  logic [RW:0]    sq_v;
  ctx_t           sq_ctx  [0:RW];
  logic [RMW-1:0] sq_rem  [0:RW];
  logic [RW-1:0]  sq_root [0:RW];
  logic [SQW-1:0] sq_val  [0:RW];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= '0;
    end else if (adv) begin
      sq_v <= {sq_v[RW-1:0], v_mul};
    end
    if (adv) begin
      sq_ctx[0]  <= sq_ctx_next;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_val[0]  <= dmag;
    end
  end

  // Square root, two radicand bits per stage.
  for (genvar k = 0; k < RW; k++) begin : g_sqrt
    logic [RMW+1:0] rem2;
    logic [RMW+1:0] trial;
    logic           ge;
    always_comb begin
      rem2  = {sq_rem[k], sq_val[k][SQW-1 -: 2]};
      trial = {2'b00, sq_root[k], 2'b01};
      ge    = rem2 >= trial;
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_ctx[k+1]  <= sq_ctx[k];
        sq_rem[k+1]  <= ge ? RMW'(rem2 - trial) : RMW'(rem2);
        sq_root[k+1] <= {sq_root[k][RW-2:0], ge};
        sq_val[k+1]  <= sq_val[k] << 2;
      end
    end
  end

  // Divider operands, with half the divisor added for rounding.
  ctx_t            pc;
  logic [DENW-1:0] nm;
  logic [DENW-1:0] a2;
  logic [NW-1:0]   num_a;
  logic [NW-1:0]   num_b;
  logic [DENW-1:0] den_a;
  logic [DENW-1:0] den_b;
  always_comb begin
    pc    = sq_ctx[RW];
    nm    = DENW'(pc.bm) + DENW'(sq_root[RW]);
    a2    = {1'b0, pc.am, 1'b0};
    num_a = '0;
    num_b = '0;
    den_a = a2;
    den_b = a2;
    if (pc.am == '0) begin
      pc.mode = (pc.bm == '0) ? MODE_NONE : MODE_LINEAR;
    end else if (pc.dneg) begin
      pc.mode = MODE_COMPLEX;
    end else if (pc.dzero) begin
      pc.mode = MODE_DOUBLE;
    end else begin
      pc.mode = MODE_TWO;
    end
    case (pc.mode)
      MODE_LINEAR: begin
        num_a = NW'(pc.cm) << F;
        den_a = DENW'(pc.bm);
      end
      MODE_DOUBLE, MODE_COMPLEX: begin
        num_a = NW'(pc.bm) << F;
        num_b = NW'(sq_root[RW]) << F;
      end
      MODE_TWO: begin
        num_a = NW'(nm) << F;
        num_b = NW'(pc.cm) << (F + 1);
        den_b = nm;
      end
      default: begin
        num_a = '0;
      end
    endcase
    num_a = num_a + NW'(den_a >> 1);
    num_b = num_b + NW'(den_b >> 1);
  end

  logic [NW:0]     dv_v;
  ctx_t            dv_ctx   [0:NW];
  logic [DENW-1:0] dv_rem_a [0:NW];
  logic [DENW-1:0] dv_rem_b [0:NW];
  logic [NW-1:0]   dv_num_a [0:NW];
  logic [NW-1:0]   dv_num_b [0:NW];
  logic [NW-1:0]   dv_q_a   [0:NW];
  logic [NW-1:0]   dv_q_b   [0:NW];
  logic [DENW-1:0] dv_den_a [0:NW];
  logic [DENW-1:0] dv_den_b [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v <= '0;
    end else if (adv) begin
      dv_v <= {dv_v[NW-1:0], sq_v[RW]};
    end
    if (adv) begin
      dv_ctx[0]   <= pc;
      dv_rem_a[0] <= '0;
      dv_rem_b[0] <= '0;
      dv_num_a[0] <= num_a;
      dv_num_b[0] <= num_b;
      dv_q_a[0]   <= '0;
      dv_q_b[0]   <= '0;
      dv_den_a[0] <= den_a;
      dv_den_b[0] <= den_b;
    end
  end

  // Restoring division, one quotient bit per stage in each divider.
  for (genvar k = 0; k < NW; k++) begin : g_div
    logic [DENW:0] ra;
    logic [DENW:0] rb;
    logic          ga;
    logic          gb;
    always_comb begin
      ra = {dv_rem_a[k], dv_num_a[k][NW-1]};
      rb = {dv_rem_b[k], dv_num_b[k][NW-1]};
      ga = ra >= {1'b0, dv_den_a[k]};
      gb = rb >= {1'b0, dv_den_b[k]};
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv_ctx[k+1]   <= dv_ctx[k];
        dv_rem_a[k+1] <= ga ? DENW'(ra - {1'b0, dv_den_a[k]}) : DENW'(ra);
        dv_rem_b[k+1] <= gb ? DENW'(rb - {1'b0, dv_den_b[k]}) : DENW'(rb);
        dv_num_a[k+1] <= dv_num_a[k] << 1;
        dv_num_b[k+1] <= dv_num_b[k] << 1;
        dv_q_a[k+1]   <= {dv_q_a[k][NW-2:0], ga};
        dv_q_b[k+1]   <= {dv_q_b[k][NW-2:0], gb};
        dv_den_a[k+1] <= dv_den_a[k];
        dv_den_b[k+1] <= dv_den_b[k];
      end
    end
  end

  // Signs of the roots and ascending order of the two real roots.
  ctx_t          fc;
  logic          n1;
  logic          n2;
  logic [NW-1:0] m1;
  logic [NW-1:0] m2;
  logic          nneg;
  logic          gt;
  always_comb begin
    fc   = dv_ctx[NW];
    m1   = dv_q_a[NW];
    m2   = dv_q_a[NW];
    n1   = 1'b0;
    nneg = (fc.bm != '0) && !fc.bn;
    gt   = 1'b0;
    case (fc.mode)
      MODE_LINEAR: begin
        n1 = !(fc.bn ^ fc.cn);
      end
      MODE_DOUBLE, MODE_COMPLEX: begin
        n1 = !(fc.an ^ fc.bn);
      end
      MODE_TWO: begin
        n1 = (nneg ^ fc.an) && (m1 != '0);
        m2 = dv_q_b[NW];
      end
      default: begin
        m1 = '0;
        m2 = '0;
      end
    endcase
    n2 = n1;
    if (fc.mode == MODE_TWO) begin
      n2 = (nneg ^ fc.cn) && (m2 != '0);
      if (n1 != n2) begin
        gt = !n1;
      end else if (n1) begin
        gt = m1 < m2;
      end else begin
        gt = m1 > m2;
      end
    end
  end

  logic          v_srt;
  mode_t         s_mode;
  logic          s_n1;
  logic          s_n2;
  logic [NW-1:0] s_m1;
  logic [NW-1:0] s_m2;
  logic [NW-1:0] s_im;
  always_ff @(posedge clk) begin
    if (rst) begin
      v_srt <= 1'b0;
    end else if (adv) begin
      v_srt <= dv_v[NW];
    end
    if (adv) begin
      s_mode <= fc.mode;
      s_n1   <= gt ? n2 : n1;
      s_m1   <= gt ? m2 : m1;
      s_n2   <= gt ? n1 : n2;
      s_m2   <= gt ? m1 : m2;
      s_im   <= dv_q_b[NW];
    end
  end

  // Saturation to the output range.
  logic [NW-1:0] lim1;
  logic [NW-1:0] lim2;
  logic          ov1;
  logic          ov2;
  logic          ovi;
  logic [W-1:0]  v1;
  logic [W-1:0]  v2;
  root_t         root_next;
  always_comb begin
    lim1 = s_n1 ? SAT_NEG : SAT_POS;
    lim2 = s_n2 ? SAT_NEG : SAT_POS;
    ov1  = s_m1 > lim1;
    ov2  = s_m2 > lim2;
    ovi  = s_im > SAT_POS;
    v1   = ov1 ? W'(lim1) : W'(s_m1);
    v2   = ov2 ? W'(lim2) : W'(s_m2);
    if (s_n1) begin
      v1 = -v1;
    end
    if (s_n2) begin
      v2 = -v2;
    end
    root_next = '0;
    case (s_mode)
      MODE_LINEAR, MODE_DOUBLE: begin
        root_next.root_kind        = KIND_SINGLE;
        root_next.first_root_real  = v1;
        root_next.second_root_real = v1;
        root_next.overflow_flag    = ov1;
      end
      MODE_COMPLEX: begin
        root_next.root_kind        = KIND_COMPLEX;
        root_next.first_root_real  = v1;
        root_next.second_root_real = v1;
        root_next.imag_magnitude   = ovi ? {(W-1){1'b1}} : s_im[W-2:0];
        root_next.overflow_flag    = ov1 | ovi;
      end
      MODE_TWO: begin
        root_next.root_kind        = KIND_TWO_REAL;
        root_next.first_root_real  = v1;
        root_next.second_root_real = v2;
        root_next.overflow_flag    = ov1 | ov2;
      end
      default: begin
        root_next.root_kind = KIND_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_valid <= 1'b0;
    end else if (adv) begin
      root_valid <= v_srt;
    end
    if (adv) begin
      root <= root_next;
    end
  end

  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_kind == KIND_NONE |->
      root.first_root_real == '0 && root.second_root_real == '0 &&
      root.imag_magnitude == '0 && !root.overflow_flag)
    else $error("no-solution beat carries nonzero fields");

  a_imag_only_complex: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_kind != KIND_COMPLEX |-> root.imag_magnitude == '0)
    else $error("imaginary part set on a real result");

  a_two_sorted: assert property (@(posedge clk) disable iff (rst)
    root_valid && root.root_kind == KIND_TWO_REAL |->
      root.first_root_real <= root.second_root_real)
    else $error("real roots out of order");

  a_pair_equal: assert property (@(posedge clk) disable iff (rst)
    root_valid && (root.root_kind == KIND_SINGLE || root.root_kind == KIND_COMPLEX) |->
      root.first_root_real == root.second_root_real)
    else $error("single root or complex pair with differing real parts");

endmodule
